// ===== rtl/core/rgbapal_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbapal_pkg
// Shared types, codes and a lookup table for the RGBA pack/unpack block.
// ----------------------------------------------------------------------------
package rgbapal_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
   localparam int CSR_AW          = 2;
   localparam int CSR_DW          = 9;

   typedef enum logic [1:0] {
      MODE_WRITE  = 2'd0,
      MODE_PACK   = 2'd1,
      MODE_UNPACK = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PIX_INDEXED = 2'd0,
      PIX_4444    = 2'd1,
      PIX_5551    = 2'd2
   } pix_fmt_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_PIXEL_FORMAT   = 2'd0,
      CSR_PALETTE_FORMAT = 2'd1,
      CSR_PALETTE_COLORS = 2'd2
   } csr_addr_type;

   typedef struct packed {
      logic ok;
      logic unpack;
      logic sel_pal;
      logic fmt5;
   } stage_ctrl_type;

   localparam logic [31:0][7:0] EXPAND5_TABLE = {
      8'd255, 8'd246, 8'd238, 8'd230, 8'd222, 8'd213, 8'd205, 8'd197,
      8'd189, 8'd180, 8'd172, 8'd164, 8'd156, 8'd148, 8'd139, 8'd131,
      8'd123, 8'd115, 8'd106, 8'd98,  8'd90,  8'd82,  8'd74,  8'd65,
      8'd57,  8'd49,  8'd41,  8'd32,  8'd24,  8'd16,  8'd8,   8'd0
   };

   function automatic logic [7:0] expand5(input logic [4:0] x);
      return EXPAND5_TABLE[x];
   endfunction

   function automatic logic [7:0] expand4(input logic [3:0] x);
      return {x, x};
   endfunction

endpackage

// ===== rtl/core/rgbapal_req_if.sv =====
// ----------------------------------------------------------------------------
// rgbapal_req_if
// Input item channel: valid/ready handshake with write, pack and unpack payload.
// ----------------------------------------------------------------------------
interface rgbapal_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  entry_index;
   logic [15:0] color_word;
   logic [7:0]  red_in;
   logic [7:0]  green_in;
   logic [7:0]  blue_in;
   logic [7:0]  alpha_in;

   modport source (
      output valid, mode, entry_index, color_word, red_in, green_in, blue_in, alpha_in,
      input  ready
   );
   modport sink (
      input  valid, mode, entry_index, color_word, red_in, green_in, blue_in, alpha_in,
      output ready
   );
endinterface

// ===== rtl/core/rgbapal_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rgbapal_rsp_if
// Result item channel: valid/ready handshake with status, packed and channels.
// ----------------------------------------------------------------------------
interface rgbapal_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [15:0] packed_color;
   logic [7:0]  red_out;
   logic [7:0]  green_out;
   logic [7:0]  blue_out;
   logic [7:0]  alpha_out;

   modport source (
      output valid, ok, packed_color, red_out, green_out, blue_out, alpha_out,
      input  ready
   );
   modport sink (
      input  valid, ok, packed_color, red_out, green_out, blue_out, alpha_out,
      output ready
   );
endinterface

// ===== rtl/core/rgbapal_csr_if.sv =====
// ----------------------------------------------------------------------------
// rgbapal_csr_if
// Register write channel: valid/ready handshake with address and data.
// ----------------------------------------------------------------------------
interface rgbapal_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rgbapal_pkg::CSR_AW-1:0] addr;
   logic [rgbapal_pkg::CSR_DW-1:0] data;

   modport source (
      output valid, addr, data,
      input  ready
   );
   modport sink (
      input  valid, addr, data,
      output ready
   );
endinterface

// ===== rtl/core/rgba_pixel_pack_unpack_palette.sv =====
// ----------------------------------------------------------------------------
// rgba_pixel_pack_unpack_palette
// Converts between 8-bit RGBA channels and 4444/5551 packed pixels, with an
// indexed palette.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled. An accepted item is
// registered in the first stage, which holds the decoded item and the palette
// read data, and then in the second, the result register. Throughput is one
// item per clock under that condition; the palette memory takes one write and
// one read per cycle, so it never holds the input. A stalled receiver holds
// the result register, then the first stage, then the input. Palette entries
// must be written (mode 0) before an indexed unpack reads them.
// Register writes are taken at any time, but must be made only while no item
// is in flight.
module rgba_pixel_pack_unpack_palette (
   input  logic         clock,
   input  logic         reset,
   rgbapal_req_if.sink  req_bus,
   rgbapal_rsp_if.source rsp_bus,
   rgbapal_csr_if.sink  csr_bus
);

   logic [1:0] pixel_format_ff, pixel_format_in;
   logic       palette_format_ff, palette_format_in;
   logic [8:0] palette_colors_ff, palette_colors_in;

   logic                         stage_valid_ff, stage_valid_in;
   rgbapal_pkg::stage_ctrl_type  ctrl_ff, ctrl_in;
   logic [15:0]                  packed_ff, packed_in;
   logic [15:0]                  word_ff, word_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [15:0] rsp_packed_ff, rsp_packed_in;
   logic [7:0]  rsp_red_ff, rsp_red_in;
   logic [7:0]  rsp_green_ff, rsp_green_in;
   logic [7:0]  rsp_blue_ff, rsp_blue_in;
   logic [7:0]  rsp_alpha_ff, rsp_alpha_in;

   logic        out_free, advance, accept;
   logic        hit_wr, hit_rd, pal_wr;
   logic [15:0] pal_rd_data;
   logic [7:0]  unp_red, unp_green, unp_blue, unp_alpha;

   localparam logic [8:0] ENTRIES_LIMIT = 9'(rgbapal_pkg::PALETTE_ENTRIES);

   // handshake
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign advance       = stage_valid_ff && out_free;
   assign req_bus.ready = !stage_valid_ff || out_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // configuration registers
   always_comb begin
      pixel_format_in   = pixel_format_ff;
      palette_format_in = palette_format_ff;
      palette_colors_in = palette_colors_ff;
      if (csr_bus.valid) begin
         case (csr_bus.addr)
            rgbapal_pkg::CSR_PIXEL_FORMAT:   pixel_format_in   = csr_bus.data[1:0];
            rgbapal_pkg::CSR_PALETTE_FORMAT: palette_format_in = csr_bus.data[0];
            rgbapal_pkg::CSR_PALETTE_COLORS: palette_colors_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff   <= rgbapal_pkg::PIX_5551;
         palette_format_ff <= 1'b1;
         palette_colors_ff <= '0;
      end else begin
         pixel_format_ff   <= pixel_format_in;
         palette_format_ff <= palette_format_in;
         palette_colors_ff <= palette_colors_in;
      end
   end

   // decode the item
   assign hit_wr = ({1'b0, req_bus.entry_index} < palette_colors_ff)
                && ({1'b0, req_bus.entry_index} < ENTRIES_LIMIT);
   assign hit_rd = ({1'b0, req_bus.color_word[7:0]} < palette_colors_ff)
                && ({1'b0, req_bus.color_word[7:0]} < ENTRIES_LIMIT);

   always_comb begin
      ctrl_in   = '0;
      packed_in = '0;
      word_in   = req_bus.color_word;
      case (req_bus.mode)
         rgbapal_pkg::MODE_WRITE: begin
            ctrl_in.ok = (pixel_format_ff == rgbapal_pkg::PIX_INDEXED) && hit_wr;
         end
         rgbapal_pkg::MODE_PACK: begin
            case (pixel_format_ff)
               rgbapal_pkg::PIX_4444: begin
                  ctrl_in.ok = 1'b1;
                  packed_in  = {req_bus.alpha_in[7:4], req_bus.blue_in[7:4],
                                req_bus.green_in[7:4], req_bus.red_in[7:4]};
               end
               rgbapal_pkg::PIX_5551: begin
                  ctrl_in.ok = 1'b1;
                  packed_in  = {req_bus.alpha_in[7], req_bus.blue_in[7:3],
                                req_bus.green_in[7:3], req_bus.red_in[7:3]};
               end
               default: ;
            endcase
         end
         rgbapal_pkg::MODE_UNPACK: begin
            ctrl_in.unpack = 1'b1;
            case (pixel_format_ff)
               rgbapal_pkg::PIX_INDEXED: begin
                  ctrl_in.ok      = hit_rd;
                  ctrl_in.sel_pal = 1'b1;
                  ctrl_in.fmt5    = palette_format_ff;
               end
               rgbapal_pkg::PIX_4444: begin
                  ctrl_in.ok = 1'b1;
               end
               rgbapal_pkg::PIX_5551: begin
                  ctrl_in.ok   = 1'b1;
                  ctrl_in.fmt5 = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign pal_wr = accept && (req_bus.mode == rgbapal_pkg::MODE_WRITE) && ctrl_in.ok;

   rgbapal_palette u_palette (
      .clock   (clock),
      .wr_en   (pal_wr),
      .wr_addr (req_bus.entry_index[rgbapal_pkg::PAL_AW-1:0]),
      .wr_data (req_bus.color_word),
      .rd_en   (accept),
      .rd_addr (req_bus.color_word[rgbapal_pkg::PAL_AW-1:0]),
      .rd_data (pal_rd_data)
   );

   // first stage
   assign stage_valid_in = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ff   <= ctrl_in;
         packed_ff <= packed_in;
         word_ff   <= word_in;
      end
   end

   rgbapal_unpack u_unpack (
      .ctrl         (ctrl_ff),
      .pixel_word   (word_ff),
      .palette_word (pal_rd_data),
      .red          (unp_red),
      .green        (unp_green),
      .blue         (unp_blue),
      .alpha        (unp_alpha)
   );

   // result register
   assign rsp_valid_in  = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_ok_in     = ctrl_ff.ok;
   assign rsp_packed_in = packed_ff;
   assign rsp_red_in    = unp_red;
   assign rsp_green_in  = unp_green;
   assign rsp_blue_in   = unp_blue;
   assign rsp_alpha_in  = unp_alpha;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ok_ff     <= rsp_ok_in;
         rsp_packed_ff <= rsp_packed_in;
         rsp_red_ff    <= rsp_red_in;
         rsp_green_ff  <= rsp_green_in;
         rsp_blue_ff   <= rsp_blue_in;
         rsp_alpha_ff  <= rsp_alpha_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.ok           = rsp_ok_ff;
   assign rsp_bus.packed_color = rsp_packed_ff;
   assign rsp_bus.red_out      = rsp_red_ff;
   assign rsp_bus.green_out    = rsp_green_ff;
   assign rsp_bus.blue_out     = rsp_blue_ff;
   assign rsp_bus.alpha_out    = rsp_alpha_ff;

endmodule

// ===== rtl/core/rgbapal_palette.sv =====
// ----------------------------------------------------------------------------
// rgbapal_palette
// Palette memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rgbapal_palette (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [rgbapal_pkg::PAL_AW-1:0] wr_addr,
   input  logic [15:0]                    wr_data,
   input  logic                           rd_en,
   input  logic [rgbapal_pkg::PAL_AW-1:0] rd_addr,
   output logic [15:0]                    rd_data
);

   logic [15:0] mem_ff [rgbapal_pkg::PALETTE_ENTRIES];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rgbapal_unpack.sv =====
// ----------------------------------------------------------------------------
// rgbapal_unpack
// Expand a 4444 or 5551 word, from the pixel or the palette, into four 8-bit channels.
// ----------------------------------------------------------------------------
module rgbapal_unpack (
   input  rgbapal_pkg::stage_ctrl_type ctrl,
   input  logic [15:0]                 pixel_word,
   input  logic [15:0]                 palette_word,
   output logic [7:0]                  red,
   output logic [7:0]                  green,
   output logic [7:0]                  blue,
   output logic [7:0]                  alpha
);

   logic [15:0] src;

   always_comb begin
      src   = ctrl.sel_pal ? palette_word : pixel_word;
      red   = '0;
      green = '0;
      blue  = '0;
      alpha = '0;
      if (ctrl.ok && ctrl.unpack) begin
         if (ctrl.fmt5) begin
            red   = rgbapal_pkg::expand5(src[4:0]);
            green = rgbapal_pkg::expand5(src[9:5]);
            blue  = rgbapal_pkg::expand5(src[14:10]);
            alpha = {8{src[15]}};
         end else begin
            red   = rgbapal_pkg::expand4(src[3:0]);
            green = rgbapal_pkg::expand4(src[7:4]);
            blue  = rgbapal_pkg::expand4(src[11:8]);
            alpha = rgbapal_pkg::expand4(src[15:12]);
         end
      end
   end

endmodule

// ===== tb/rgba_pixel_pack_unpack_palette_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgba_pixel_pack_unpack_palette_tb
// Self-checking bench for the RGBA pack/unpack block with indexed palette.
// A short directed table walks the reset settings, channel extremes, palette
// bounds and the unused mode code. Random phases then sweep several register
// settings, the unused format code among them, under different handshake back-pressure. Every
// result is compared field by field against a value given in the directed table
// or from a local pixel converter that tracks the register settings and palette contents.
// ----------------------------------------------------------------------------
module rgba_pixel_pack_unpack_palette_tb;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [1:0] PIX_UNUSED  = 2'd3;
   localparam int         HALF_PERIOD = 4;
   localparam int         RESET_CYCLES = 12;
   localparam int         SETTLE_CYCLES = 4;
   localparam int         RUN_LIMIT_NS = 4000000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  entry_index;
      logic [15:0] color_word;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
   } pixel_item_type;

   typedef struct packed {
      logic        ok;
      logic [15:0] packed_color;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
   } pixel_result_type;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      rgbapal_pkg::csr_addr_type addr;
      logic [8:0]                data;
      pixel_item_type            item;
      logic                      has_typed;
      pixel_result_type          typed_res;
   } dir_row_type;

   typedef struct packed {
      logic [1:0] pix;
      logic       pal;
      logic [8:0] colors;
      logic [6:0] idle_pct;
      logic [6:0] stall_pct;
      logic [9:0] count;
   } phase_type;

   localparam pixel_result_type REJECTED = '0;
   localparam pixel_result_type ALL_ZERO_OK =
      '{1'b1, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam pixel_result_type ALL_FULL_OK =
      '{1'b1, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
   localparam pixel_item_type   NO_ITEM = '0;

   localparam int DIR_ROWS = 30;
   localparam dir_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      // reset settings: 5551 pixels, 5551 palette, no palette
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_PACK, 8'h00, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        1'b1, '{1'b1, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00}},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_PACK, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, ALL_ZERO_OK},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_UNPACK, 8'h00, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, ALL_FULL_OK},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_UNPACK, 8'hFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        1'b1, ALL_ZERO_OK},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_WRITE, 8'h00, 16'h1234, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{MODE_UNUSED, 8'h00, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        1'b1, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_PACK, 8'h00, 16'h0000, 8'h08, 8'h10, 8'h80, 8'h7F},
        1'b0, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_UNPACK, 8'h00, 16'h8421, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b0, REJECTED},
      '{ROW_CSR, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'(rgbapal_pkg::PIX_4444), NO_ITEM,
        1'b0, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_PACK, 8'h00, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        1'b1, '{1'b1, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00}},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_UNPACK, 8'h00, 16'h1234, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b0, REJECTED},
      '{ROW_CSR, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'(rgbapal_pkg::PIX_INDEXED), NO_ITEM,
        1'b0, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_WRITE, 8'h00, 16'h1234, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_UNPACK, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_PACK, 8'h00, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        1'b1, REJECTED},
      '{ROW_CSR, rgbapal_pkg::CSR_PALETTE_COLORS, 9'd256, NO_ITEM, 1'b0, REJECTED},
      '{ROW_CSR, rgbapal_pkg::CSR_PALETTE_FORMAT, 9'd0, NO_ITEM, 1'b0, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_WRITE, 8'hFF, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, ALL_ZERO_OK},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_WRITE, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, ALL_ZERO_OK},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_WRITE, 8'h10, 16'hA5C3, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, ALL_ZERO_OK},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_UNPACK, 8'h00, 16'hABFF, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, ALL_FULL_OK},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_UNPACK, 8'h00, 16'h5500, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, ALL_ZERO_OK},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_UNPACK, 8'h00, 16'h0010, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b0, REJECTED},
      '{ROW_CSR, rgbapal_pkg::CSR_PALETTE_FORMAT, 9'd1, NO_ITEM, 1'b0, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_UNPACK, 8'h00, 16'h0010, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b0, REJECTED},
      '{ROW_CSR, rgbapal_pkg::CSR_PALETTE_COLORS, 9'd16, NO_ITEM, 1'b0, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_WRITE, 8'h10, 16'h1111, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_WRITE, 8'h0F, 16'h7FFF, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, ALL_ZERO_OK},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_UNPACK, 8'h00, 16'h000F, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b0, REJECTED},
      '{ROW_ITEM, rgbapal_pkg::CSR_PIXEL_FORMAT, 9'd0,
        '{rgbapal_pkg::MODE_UNPACK, 8'h00, 16'h0010, 8'h00, 8'h00, 8'h00, 8'h00},
        1'b1, REJECTED}
   };

   localparam int PHASE_COUNT = 11;
   localparam phase_type PHASES [PHASE_COUNT] = '{
      '{PIX_UNUSED,               1'b1, 9'd16,  7'd0,  7'd0,  10'd30},
      '{rgbapal_pkg::PIX_INDEXED, 1'b0, 9'd256, 7'd0,  7'd0,  10'd240},
      '{rgbapal_pkg::PIX_INDEXED, 1'b1, 9'd16,  7'd71, 7'd0,  10'd190},
      '{rgbapal_pkg::PIX_4444,    1'b1, 9'd16,  7'd0,  7'd71, 10'd190},
      '{rgbapal_pkg::PIX_5551,    1'b0, 9'd0,   7'd18, 7'd18, 10'd190},
      '{rgbapal_pkg::PIX_INDEXED, 1'b1, 9'd37,  7'd18, 7'd18, 10'd190},
      '{rgbapal_pkg::PIX_INDEXED, 1'b0, 9'd0,   7'd0,  7'd0,  10'd90},
      '{PIX_UNUSED,               1'b1, 9'd511, 7'd71, 7'd0,  10'd90},
      '{rgbapal_pkg::PIX_INDEXED, 1'b1, 9'd511, 7'd0,  7'd71, 10'd140},
      '{rgbapal_pkg::PIX_4444,    1'b0, 9'd256, 7'd18, 7'd18, 10'd140},
      '{rgbapal_pkg::PIX_5551,    1'b1, 9'd256, 7'd71, 7'd71, 10'd90}
   };

   logic clock;
   logic reset;

   rgbapal_req_if req_bus ();
   rgbapal_rsp_if rsp_bus ();
   rgbapal_csr_if csr_bus ();

   rgba_pixel_pack_unpack_palette dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic [1:0]       cfg_pix_fmt;
   logic             cfg_pal_fmt;
   logic [8:0]       cfg_colors;
   logic [15:0]      palette_model [rgbapal_pkg::PALETTE_ENTRIES];
   bit               palette_written [rgbapal_pkg::PALETTE_ENTRIES];
   pixel_result_type expected_pixels [$];

   int sender_idle_pct;
   int receiver_stall_pct;
   int mismatch_count;
   int items_sent;
   int results_ok;
   int results_rejected;
   int settings_used;

   always #(HALF_PERIOD) clock = ~clock;

   function automatic pixel_result_type unpack_word(input logic fmt5, input logic [15:0] w);
      pixel_result_type res;
      res = '0;
      res.ok = 1'b1;
      if (fmt5) begin
         res.red   = 8'(int'(w[4:0]) * 255 / 31);
         res.green = 8'(int'(w[9:5]) * 255 / 31);
         res.blue  = 8'(int'(w[14:10]) * 255 / 31);
         res.alpha = w[15] ? 8'hFF : 8'h00;
      end else begin
         res.red   = 8'(int'(w[3:0]) * 17);
         res.green = 8'(int'(w[7:4]) * 17);
         res.blue  = 8'(int'(w[11:8]) * 17);
         res.alpha = 8'(int'(w[15:12]) * 17);
      end
      return res;
   endfunction

   function automatic pixel_result_type convert_pixel(input pixel_item_type it);
      pixel_result_type res;
      logic [7:0]       pidx;
      res = '0;
      pidx = it.color_word[7:0];
      case (it.mode)
         rgbapal_pkg::MODE_WRITE: begin
            if (cfg_pix_fmt == rgbapal_pkg::PIX_INDEXED && it.entry_index < cfg_colors) begin
               palette_model[it.entry_index] = it.color_word;
               palette_written[it.entry_index] = 1'b1;
               res.ok = 1'b1;
            end
         end
         rgbapal_pkg::MODE_PACK: begin
            if (cfg_pix_fmt == rgbapal_pkg::PIX_4444) begin
               res.ok = 1'b1;
               res.packed_color = {it.alpha[7:4], it.blue[7:4], it.green[7:4], it.red[7:4]};
            end else if (cfg_pix_fmt == rgbapal_pkg::PIX_5551) begin
               res.ok = 1'b1;
               res.packed_color = {it.alpha[7], it.blue[7:3], it.green[7:3], it.red[7:3]};
            end
         end
         rgbapal_pkg::MODE_UNPACK: begin
            if (cfg_pix_fmt == rgbapal_pkg::PIX_INDEXED) begin
               if (pidx < cfg_colors)
                  res = unpack_word(cfg_pal_fmt, palette_model[pidx]);
            end else if (cfg_pix_fmt == rgbapal_pkg::PIX_4444 ||
                         cfg_pix_fmt == rgbapal_pkg::PIX_5551) begin
               res = unpack_word(cfg_pix_fmt == rgbapal_pkg::PIX_5551, it.color_word);
            end
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_req(input pixel_item_type it, input bit has_typed,
                           input pixel_result_type typed_res);
      pixel_result_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= it.mode;
      req_bus.entry_index <= it.entry_index;
      req_bus.color_word  <= it.color_word;
      req_bus.red_in      <= it.red;
      req_bus.green_in    <= it.green;
      req_bus.blue_in     <= it.blue;
      req_bus.alpha_in    <= it.alpha;
      do @(posedge clock); while (!req_bus.ready);
      predicted = convert_pixel(it);
      expected_pixels.push_back(has_typed ? typed_res : predicted);
      items_sent++;
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input rgbapal_pkg::csr_addr_type addr, input logic [8:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= addr;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (addr)
         rgbapal_pkg::CSR_PIXEL_FORMAT:   cfg_pix_fmt = data[1:0];
         rgbapal_pkg::CSR_PALETTE_FORMAT: cfg_pal_fmt = data[0];
         rgbapal_pkg::CSR_PALETTE_COLORS: cfg_colors  = data;
         default: ;
      endcase
      settings_used++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // pick a mode and payload; indexed unpacks only touch written entries or miss the palette
   task automatic gen_item(output pixel_item_type it);
      int   pick;
      int   span;
      int   tries;
      bit   found;
      logic [7:0] idx;
      it.entry_index = 8'($urandom);
      it.color_word  = 16'($urandom);
      it.red         = 8'($urandom);
      it.green       = 8'($urandom);
      it.blue        = 8'($urandom);
      it.alpha       = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 5)       it.mode = MODE_UNUSED;
      else if (pick < 30) it.mode = rgbapal_pkg::MODE_WRITE;
      else if (pick < 58) it.mode = rgbapal_pkg::MODE_PACK;
      else                it.mode = rgbapal_pkg::MODE_UNPACK;
      span = (cfg_colors > rgbapal_pkg::PALETTE_ENTRIES) ?
             rgbapal_pkg::PALETTE_ENTRIES : int'(cfg_colors);
      if (it.mode == rgbapal_pkg::MODE_WRITE && span > 0 && $urandom_range(9) < 8)
         it.entry_index = 8'($urandom_range(span - 1));
      if (it.mode == rgbapal_pkg::MODE_UNPACK && cfg_pix_fmt == rgbapal_pkg::PIX_INDEXED) begin
         found = 1'b0;
         idx = 8'h00;
         tries = 0;
         if (span > 0 && $urandom_range(9) < 8) begin
            while (!found && tries < 64) begin
               idx = 8'($urandom_range(span - 1));
               found = palette_written[idx];
               tries++;
            end
         end
         if (!found && span < rgbapal_pkg::PALETTE_ENTRIES) begin
            idx = 8'($urandom_range(rgbapal_pkg::PALETTE_ENTRIES - 1, span));
            found = 1'b1;
         end
         if (found)
            it.color_word[7:0] = idx;
         else
            it.mode = rgbapal_pkg::MODE_PACK;
      end
   endtask

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result", 16'(rsp_bus.ok), 16'h0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_bus.ok !== want.ok)
               report_mismatch("ok", 16'(rsp_bus.ok), 16'(want.ok));
            if (rsp_bus.packed_color !== want.packed_color)
               report_mismatch("packed_color", rsp_bus.packed_color, want.packed_color);
            if (rsp_bus.red_out !== want.red)
               report_mismatch("red_out", 16'(rsp_bus.red_out), 16'(want.red));
            if (rsp_bus.green_out !== want.green)
               report_mismatch("green_out", 16'(rsp_bus.green_out), 16'(want.green));
            if (rsp_bus.blue_out !== want.blue)
               report_mismatch("blue_out", 16'(rsp_bus.blue_out), 16'(want.blue));
            if (rsp_bus.alpha_out !== want.alpha)
               report_mismatch("alpha_out", 16'(rsp_bus.alpha_out), 16'(want.alpha));
            if (want.ok) results_ok++;
            else         results_rejected++;
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d results outstanding", expected_pixels.size());
      $display("tb: failure");
      $finish;
   end

   initial begin
      pixel_item_type it;
      phase_type      ph;
      clock               = 1'b0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.mode        = rgbapal_pkg::MODE_WRITE;
      req_bus.entry_index = '0;
      req_bus.color_word  = '0;
      req_bus.red_in      = '0;
      req_bus.green_in    = '0;
      req_bus.blue_in     = '0;
      req_bus.alpha_in    = '0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.addr        = rgbapal_pkg::CSR_PIXEL_FORMAT;
      csr_bus.data        = '0;
      cfg_pix_fmt         = rgbapal_pkg::PIX_5551;
      cfg_pal_fmt         = 1'b1;
      cfg_colors          = '0;
      sender_idle_pct     = 0;
      receiver_stall_pct  = 0;
      mismatch_count      = 0;
      items_sent          = 0;
      results_ok          = 0;
      results_rejected    = 0;
      settings_used       = 0;
      foreach (palette_written[i]) palette_written[i] = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (DIRECTED_ROWS[r].kind == ROW_CSR) begin
            wait_results_done();
            csr_write(DIRECTED_ROWS[r].addr, DIRECTED_ROWS[r].data);
         end else begin
            send_req(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].has_typed,
                     DIRECTED_ROWS[r].typed_res);
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         ph = PHASES[p];
         wait_results_done();
         csr_write(rgbapal_pkg::CSR_PIXEL_FORMAT, 9'(ph.pix));
         csr_write(rgbapal_pkg::CSR_PALETTE_FORMAT, 9'(ph.pal));
         csr_write(rgbapal_pkg::CSR_PALETTE_COLORS, ph.colors);
         sender_idle_pct    = ph.idle_pct;
         receiver_stall_pct = ph.stall_pct;
         for (int n = 0; n < ph.count; n++) begin
            // halfway through the phase, hold the sender until the pipeline is empty
            if (n == ph.count / 2)
               wait_results_done();
            gen_item(it);
            send_req(it, 1'b0, REJECTED);
         end
      end

      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d items sent across %0d register writes and %0d random phases",
               items_sent, settings_used, PHASE_COUNT);
      $display("summary: %0d results compared, %0d successful, %0d rejected, %0d mismatches",
               results_ok + results_rejected, results_ok, results_rejected, mismatch_count);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== rgba_pixel_pack_unpack_palette.f =====
rtl/core/rgbapal_pkg.sv
rtl/core/rgbapal_req_if.sv
rtl/core/rgbapal_rsp_if.sv
rtl/core/rgbapal_csr_if.sv
rtl/core/rgbapal_palette.sv
rtl/core/rgbapal_unpack.sv
rtl/core/rgba_pixel_pack_unpack_palette.sv
tb/rgba_pixel_pack_unpack_palette_tb.sv
